// ===== hdl/spiee_pkg.sv =====
// Shared types and constants for the SPI EEPROM bit-bang master.
// Holds the transfer structs, the command and sequencer enums and the opcodes.
// No dependencies; every other file in hdl/ imports this package.
`default_nettype none

package spiee_pkg;

    // Codes of the kind field on the input channel.
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    // EEPROM opcodes.
    localparam logic [7:0] OP_WRITE = 8'h02;
    localparam logic [7:0] OP_READ  = 8'h03;
    localparam logic [7:0] OP_RDSR  = 8'h05;
    localparam logic [7:0] OP_WREN  = 8'h06;
    localparam logic [7:0] DUMMY_BYTE = 8'h00;

    // Depth of the command queue between front and back.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic        miso;
    } t_in_item;

    typedef struct packed {
        logic       cs_n;
        logic       sclk;
        logic       mosi;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
    } t_out_item;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic        miso;
    } t_cmd;

    typedef struct packed {
        logic push;
        t_cmd cmd;
    } t_q_push;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_CSLOW  = 2'd1,
        PH_BITS   = 2'd2,
        PH_CSHIGH = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        FR_READ  = 2'd0,
        FR_WREN  = 2'd1,
        FR_WRITE = 2'd2,
        FR_RDSR  = 2'd3
    } t_frame;

endpackage

`default_nettype wire

// ===== hdl/spiee_front.sv =====
// Front end of the SPI EEPROM master: accepts input transfers and classifies them.
// Depends on spiee_pkg; feeds spiee_queue.
`default_nettype none

module spiee_front (
    input  wire logic               i_in_valid,
    input  spiee_pkg::t_in_item     i_in_item,
    input  wire logic               i_q_full,
    output logic                    o_in_stall,
    output spiee_pkg::t_q_push      o_push
);
    import spiee_pkg::*;

    logic known;

    // An unused kind code is accepted and dropped here, so it never reaches the sequencer.
    always_comb begin
        known                  = 1'b1;
        o_push.cmd.kind        = CMD_TICK;
        o_push.cmd.address     = i_in_item.address;
        o_push.cmd.write_data  = i_in_item.write_data;
        o_push.cmd.miso        = i_in_item.miso;
        unique case (i_in_item.kind)
            KIND_TICK:  o_push.cmd.kind = CMD_TICK;
            KIND_READ:  o_push.cmd.kind = CMD_READ;
            KIND_WRITE: o_push.cmd.kind = CMD_WRITE;
            default:    known = 1'b0;
        endcase
        o_push.push = i_in_valid && !i_q_full && known;
    end

    assign o_in_stall = i_q_full;

endmodule

`default_nettype wire

// ===== hdl/spiee_queue.sv =====
// Two-entry command queue between the front end and the pin sequencer.
// Depends on spiee_pkg.
`default_nettype none

module spiee_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  spiee_pkg::t_q_push      i_push,
    input  wire logic               i_pop,
    output spiee_pkg::t_q_head      o_head,
    output logic                    o_full
);
    import spiee_pkg::*;

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;
    logic              do_pop;

    assign o_full       = (r_count == QCNT_W'(QDEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_mem[r_rd_ptr];
    assign do_pop       = i_pop && o_head.valid;

    always_comb begin
        n_count = r_count;
        if (i_push.push && !do_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!i_push.push && do_pop) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr_ptr] <= i_push.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push.push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_push_when_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push.push)
        else $error("queue pushed while full");
    a_count_in_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("queue count beyond depth");
    a_pop_then_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_pop && !i_push.push) |=> (r_count == $past(r_count) - QCNT_W'(1)))
        else $error("queue count did not follow a pop");
`endif

endmodule

`default_nettype wire

// ===== hdl/spiee_seq.sv =====
// Pin sequencer of the SPI EEPROM master: runs the frame sequences and owns the
// output register. Depends on spiee_pkg; takes commands from spiee_queue.
`default_nettype none

module spiee_seq #(
    parameter int ADDR_WIDTH = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  spiee_pkg::t_q_head      i_head,
    output logic                    o_pop,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output spiee_pkg::t_out_item    o_out_item
);
    import spiee_pkg::*;

    localparam int FRAME_W = ADDR_WIDTH + 16;
    localparam int CNT_W   = $clog2(FRAME_W + 1);

    t_phase                r_phase;
    t_phase                n_phase;
    t_frame                r_frame;
    t_frame                n_frame;
    logic [FRAME_W-1:0]    r_tx;
    logic [FRAME_W-1:0]    n_tx;
    logic [7:0]            r_rx;
    logic [7:0]            n_rx;
    logic                  r_rx_pending;
    logic                  n_rx_pending;
    logic [CNT_W-1:0]      r_bits;
    logic [CNT_W-1:0]      n_bits;
    logic                  r_clock_half;
    logic                  n_clock_half;
    logic [ADDR_WIDTH-1:0] r_park_addr;
    logic [ADDR_WIDTH-1:0] n_park_addr;
    logic [7:0]            r_park_data;
    logic [7:0]            n_park_data;
    logic [7:0]            r_held;
    logic [7:0]            n_held;
    logic                  r_out_valid;
    t_out_item             r_out;
    t_out_item             n_out;

    logic                      slot_free;
    logic                      is_tick;
    logic                      is_req;
    logic [7:0]                rx_now;
    logic [ADDR_WIDTH+15:0]    addr_wide;
    logic [ADDR_WIDTH-1:0]     addr_cut;

    // Frame contents, left aligned so that the MSB is always the next bit out.
    function automatic logic [FRAME_W-1:0] frame_bits(input t_frame f,
                                                      input logic [ADDR_WIDTH-1:0] a,
                                                      input logic [7:0] d);
        logic [FRAME_W-1:0] v;
        begin
            unique case (f)
                FR_READ:  v = {OP_READ, a, DUMMY_BYTE};
                FR_WRITE: v = {OP_WRITE, a, d};
                FR_WREN:  v = {OP_WREN, (FRAME_W - 8)'(0)};
                FR_RDSR:  v = {OP_RDSR, DUMMY_BYTE, (FRAME_W - 16)'(0)};
            endcase
            return v;
        end
    endfunction

    function automatic logic [CNT_W-1:0] frame_len(input t_frame f);
        logic [CNT_W-1:0] v;
        begin
            unique case (f)
                FR_READ, FR_WRITE: v = CNT_W'(FRAME_W);
                FR_WREN:           v = CNT_W'(8);
                FR_RDSR:           v = CNT_W'(16);
            endcase
            return v;
        end
    endfunction

    assign slot_free = !r_out_valid || !i_out_stall;
    assign is_tick   = (i_head.cmd.kind == CMD_TICK);
    assign is_req    = (i_head.cmd.kind == CMD_READ) || (i_head.cmd.kind == CMD_WRITE);
    assign o_pop     = i_head.valid && (!is_tick || slot_free);

    // MISO of a clock-high sample arrives with the following tick.
    assign rx_now    = r_rx_pending ? {r_rx[6:0], i_head.cmd.miso} : r_rx;
    assign addr_wide = {{ADDR_WIDTH{1'b0}}, i_head.cmd.address};
    assign addr_cut  = addr_wide[ADDR_WIDTH-1:0];

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (is_req) begin
            if (r_phase == PH_IDLE) begin
                n_phase = PH_CSLOW;
            end
        end else if (is_tick) begin
            unique case (r_phase)
                PH_IDLE:  n_phase = PH_IDLE;
                PH_CSLOW: n_phase = PH_BITS;
                PH_BITS: begin
                    if (r_bits == '0) begin
                        n_phase = PH_CSHIGH;
                    end else if (r_clock_half && r_bits == CNT_W'(1)) begin
                        n_phase = PH_CSHIGH;
                    end
                end
                PH_CSHIGH: begin
                    unique case (r_frame)
                        FR_READ:           n_phase = PH_IDLE;
                        FR_WREN, FR_WRITE: n_phase = PH_CSLOW;
                        FR_RDSR:           n_phase = rx_now[0] ? PH_CSLOW : PH_IDLE;
                    endcase
                end
            endcase
        end
    end

    // Datapath and pin outputs.
    always_comb begin
        n_frame      = r_frame;
        n_tx         = r_tx;
        n_rx         = r_rx;
        n_rx_pending = r_rx_pending;
        n_bits       = r_bits;
        n_clock_half = r_clock_half;
        n_park_addr  = r_park_addr;
        n_park_data  = r_park_data;
        n_held       = r_held;
        n_out.cs_n   = 1'b1;
        n_out.sclk   = 1'b0;
        n_out.mosi   = 1'b0;
        n_out.done_res = 1'b0;

        unique case (i_head.cmd.kind)
            CMD_READ, CMD_WRITE: begin
                if (r_phase == PH_IDLE) begin
                    n_rx         = '0;
                    n_rx_pending = 1'b0;
                    n_clock_half = 1'b0;
                    n_park_addr  = addr_cut;
                    n_park_data  = i_head.cmd.write_data;
                    n_frame      = (i_head.cmd.kind == CMD_WRITE) ? FR_WREN : FR_READ;
                    n_tx         = frame_bits(n_frame, addr_cut, 8'h00);
                    n_bits       = frame_len(n_frame);
                end
            end
            CMD_TICK: begin
                n_rx         = rx_now;
                n_rx_pending = 1'b0;
                unique case (r_phase)
                    PH_IDLE: ;
                    PH_CSLOW: n_out.cs_n = 1'b0;
                    PH_BITS: begin
                        n_out.cs_n = 1'b0;
                        if (r_bits != '0) begin
                            n_out.mosi = r_tx[FRAME_W-1];
                            if (!r_clock_half) begin
                                n_clock_half = 1'b1;
                            end else begin
                                n_out.sclk   = 1'b1;
                                n_clock_half = 1'b0;
                                n_rx_pending = 1'b1;
                                n_bits       = r_bits - CNT_W'(1);
                                n_tx         = {r_tx[FRAME_W-2:0], 1'b0};
                            end
                        end
                    end
                    PH_CSHIGH: begin
                        unique case (r_frame)
                            FR_READ: begin
                                n_held         = rx_now;
                                n_out.done_res = 1'b1;
                            end
                            FR_WREN: begin
                                n_frame      = FR_WRITE;
                                n_tx         = frame_bits(FR_WRITE, r_park_addr, r_park_data);
                                n_bits       = frame_len(FR_WRITE);
                                n_clock_half = 1'b0;
                            end
                            FR_WRITE: begin
                                n_frame      = FR_RDSR;
                                n_tx         = frame_bits(FR_RDSR, r_park_addr, r_park_data);
                                n_bits       = frame_len(FR_RDSR);
                                n_clock_half = 1'b0;
                            end
                            FR_RDSR: begin
                                if (rx_now[0]) begin
                                    n_tx         = frame_bits(FR_RDSR, r_park_addr, r_park_data);
                                    n_bits       = frame_len(FR_RDSR);
                                    n_clock_half = 1'b0;
                                end else begin
                                    n_out.done_res = 1'b1;
                                end
                            end
                        endcase
                    end
                endcase
            end
            default: ;
        endcase

        n_out.busy_res  = (n_phase != PH_IDLE);
        n_out.read_data = n_held;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_frame      <= FR_READ;
            r_rx         <= '0;
            r_rx_pending <= 1'b0;
            r_bits       <= '0;
            r_clock_half <= 1'b0;
            r_held       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase      <= n_phase;
                r_frame      <= n_frame;
                r_rx         <= n_rx;
                r_rx_pending <= n_rx_pending;
                r_bits       <= n_bits;
                r_clock_half <= n_clock_half;
                r_held       <= n_held;
            end
            if (o_pop && is_tick) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_tx        <= n_tx;
            r_park_addr <= n_park_addr;
            r_park_data <= n_park_data;
        end
        if (o_pop && is_tick) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef SYNTHESIS
    a_done_ends_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.done_res) |-> !r_out.busy_res)
        else $error("done sample still reports busy");
    a_sclk_needs_cs : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.sclk) |-> !r_out.cs_n)
        else $error("serial clock high with chip select inactive");
    a_half_only_in_bits : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clock_half |-> (r_phase == PH_BITS))
        else $error("clock half flag set outside the bit phase");
    a_no_pop_into_full_slot : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && is_tick) |-> slot_free)
        else $error("tick popped with the output register occupied");
`endif

endmodule

`default_nettype wire

// ===== hdl/spi_eeprom_bitbang_master_top.sv =====
// Top level of the SPI EEPROM bit-bang master (25-series, mode 0).
// Depends on spiee_pkg and instantiates spiee_front, spiee_queue and spiee_seq.
`default_nettype none

// Usage
// The input channel (i_in_valid, o_in_stall, i_in_item) carries ticks and requests.
// A tick asks for one pin sample; it always yields exactly one result transfer on
// the output channel (o_out_valid, i_out_stall, o_out_item) with cs_n, sclk, mosi,
// busy, done and the last byte read. A read or write request yields no result; it
// starts a frame sequence if the sequencer is idle and is otherwise ignored, as is
// the unused kind code. The miso field of a tick is the level seen during the
// sample driven before it.
// Throughput is one item per clock cycle, sustained unless the receiver stalls: the
// front end classifies an item in the cycle it is accepted, a two-entry queue
// decouples it from the pin sequencer, and the sequencer handles one command per
// cycle. The result of a tick passes through the queue to the output register.
// When the receiver stalls, the result is held in the output register, ticks back
// up into the queue, and o_in_stall rises once the queue holds two commands.
// Requests drain in order while the output stalls, until a tick heads the queue.
// Reset (synchronous, active low) empties the queue and the output register and
// returns the sequencer to idle with a held read byte of zero.
module spi_eeprom_bitbang_master_top #(
    parameter int ADDR_WIDTH = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  spiee_pkg::t_in_item     i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output spiee_pkg::t_out_item    o_out_item
);
    import spiee_pkg::*;

    t_q_push q_push;
    t_q_head q_head;
    logic    q_full;
    logic    q_pop;

    // Front end: takes input transfers and turns them into queue commands.
    spiee_front u_front (
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .i_q_full   (q_full),
        .o_in_stall (o_in_stall),
        .o_push     (q_push)
    );

    // Short queue so that the two halves stall independently.
    spiee_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_full  (q_full)
    );

    // Back end: frame sequencer and output register.
    spiee_seq #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (q_head),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

`ifndef SYNTHESIS
    a_stall_held_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed or vanished");
    a_idle_tick_pins : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.busy_res && !o_out_item.done_res)
            |-> (o_out_item.cs_n && !o_out_item.sclk && !o_out_item.mosi))
        else $error("idle sample drives active pins");
    a_stall_only_when_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> q_full)
        else $error("input stalled with room in the queue");
`endif

endmodule

`default_nettype wire
